// ----- hw/rtl/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types, codes and helpers of the column statistics reducer.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int VALUE_W = 48;

  localparam logic [3:0] MODE_MIN  = 4'd0;
  localparam logic [3:0] MODE_MAX  = 4'd1;
  localparam logic [3:0] MODE_SUM  = 4'd2;
  localparam logic [3:0] MODE_MEAN = 4'd3;
  localparam logic [3:0] MODE_AVG  = 4'd4;
  localparam logic [3:0] MODE_STD  = 4'd5;
  localparam logic [3:0] MODE_STD1 = 4'd6;
  localparam logic [3:0] MODE_VAR  = 4'd7;
  localparam logic [3:0] MODE_VAR1 = 4'd8;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_MISSING = 2'd1;
  localparam logic [1:0] CFG_SKIP    = 2'd2;

  localparam logic signed [63:0] VALUE_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] VALUE_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic capture;
    logic accum;
    logic mul_clr;
    logic mul_step;
    logic mul_store;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic finish;
  } crs_cmd_t;

  typedef struct packed {
    logic last;
    logic need_var;
    logic need_mean;
    logic need_sqrt;
  } crs_stat_t;

  function automatic logic [VALUE_W-1:0] sat48(input logic signed [63:0] v);
    logic [VALUE_W-1:0] r;
    if (v > VALUE_MAX) r = VALUE_MAX[VALUE_W-1:0];
    else if (v < VALUE_MIN) r = VALUE_MIN[VALUE_W-1:0];
    else r = v[VALUE_W-1:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/crs_ctrl.sv -----
// ----------------------------------------------------------------------------
// crs_ctrl
// Sequencer: sample accumulation, product, divide and root phases, output.
// ----------------------------------------------------------------------------
module crs_ctrl import crs_pkg::*; #(
  parameter int NDIG = 4,
  parameter int DVW  = 138
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  crs_stat_t stat,
  output crs_cmd_t  cmd
);

  localparam int CNTW = $clog2(DVW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DLD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_SQLD = 3'd5;
  localparam logic [2:0] ST_SQRT = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]      state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [1:0]      pcnt, pcnt_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    pcnt_next  = pcnt;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (!stat.last) state_next = ST_IDLE;
        else if (stat.need_var) begin
          cmd.mul_clr = 1'b1;
          cnt_next    = '0;
          pcnt_next   = '0;
          state_next  = ST_MUL;
        end else if (stat.need_mean) state_next = ST_DLD;
        else state_next = ST_FIN;
      end
      ST_MUL: begin
        if (cnt == CNTW'(NDIG)) begin
          cmd.mul_store = 1'b1;
          cnt_next      = '0;
          if (pcnt == 2'd2) state_next = ST_DLD;
          else pcnt_next = pcnt + 2'd1;
        end else begin
          cmd.mul_step = 1'b1;
          cnt_next     = cnt + 1'b1;
        end
      end
      ST_DLD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNTW'(DVW - 1)) state_next = stat.need_sqrt ? ST_SQLD : ST_FIN;
        else cnt_next = cnt + 1'b1;
      end
      ST_SQLD: begin
        cmd.sqrt_load = 1'b1;
        cnt_next      = '0;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == CNTW'(31)) state_next = ST_FIN;
        else cnt_next = cnt + 1'b1;
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      pcnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pcnt  <= pcnt_next;
      if (cmd.finish) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign s_tready = (state == ST_IDLE);

  ap_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.accum, cmd.mul_step, cmd.mul_store, cmd.div_load,
              cmd.div_step, cmd.sqrt_load, cmd.sqrt_step, cmd.finish}))
    else $error("more than one datapath command in a cycle");

  ap_accept_then_acc: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_ACC))
    else $error("accepted beat not followed by accumulation");

  ap_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (m_tvalid && state == ST_IDLE))
    else $error("finished column not presented");

  ap_div_after_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && $past(state) != ST_DIV) |-> ($past(state) == ST_DLD))
    else $error("divide entered without operand load");

endmodule

// ----- hw/rtl/crs_datapath.sv -----
// ----------------------------------------------------------------------------
// crs_datapath
// Config registers, column accumulators, digit multiplier, divider, root.
// ----------------------------------------------------------------------------
module crs_datapath import crs_pkg::*; #(
  parameter int MAX_COLUMN_LENGTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  sample,
  input  logic [15:0]         weight,
  input  logic                weight_missing,
  input  logic                last_in_column,
  input  crs_cmd_t            cmd,
  output crs_stat_t           stat,
  output logic [VALUE_W-1:0]  value,
  output logic                is_missing
);

  localparam int CW   = $clog2(MAX_COLUMN_LENGTH + 1);
  localparam int SW   = 16 + CW;
  localparam int WSW  = 32 + CW;
  localparam int QSW  = 48 + CW;
  localparam int WQW  = 32 + CW;
  localparam int OW   = QSW;
  localparam int PW   = 2 * OW;
  localparam int DENW = 2 * SW;
  localparam int DVW  = PW + 16;
  localparam int NDIG = (OW + 15) / 16;
  localparam int DGW  = $clog2(NDIG);

  // configuration
  logic [3:0]         mode;
  logic signed [15:0] missing_value;
  logic               skip_missing;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_MIN;
      missing_value <= -16'sd32768;
      skip_missing  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:    mode          <= cfg_data[3:0];
        CFG_MISSING: missing_value <= cfg_data;
        CFG_SKIP:    skip_missing  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sample stage: products of the beat
  logic signed [15:0] s1_s;
  logic [15:0]        s1_w;
  logic               s1_smiss, s1_wmiss, s1_last;
  logic [30:0]        s1_mm;
  logic signed [31:0] s1_ws;
  logic [31:0]        s1_ww;
  logic [15:0]        in_mag;
  logic [31:0]        in_ws_full;

  assign in_mag     = sample[15] ? 16'(-sample) : 16'(sample);
  assign in_ws_full = 32'($signed({1'b0, weight}) * sample);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s1_s     <= sample;
      s1_w     <= weight;
      s1_smiss <= skip_missing && (sample == missing_value);
      s1_wmiss <= skip_missing && weight_missing;
      s1_mm    <= 31'(in_mag * in_mag);
      s1_ws    <= in_ws_full;
      s1_ww    <= weight * weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_last <= 1'b0;
    else if (cmd.capture) s1_last <= last_in_column;
  end

  // column accumulators
  logic [CW-1:0]        count;
  logic signed [15:0]   rmin, rmax;
  logic signed [SW-1:0] psum;
  logic signed [WSW-1:0] wsum_s;
  logic [SW-1:0]        wtot;
  logic [QSW-1:0]       wsq;
  logic [WQW-1:0]       wq;
  logic                 poisoned;

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count    <= '0;
      rmin     <= 16'sd32767;
      rmax     <= -16'sd32768;
      psum     <= '0;
      wsum_s   <= '0;
      wtot     <= '0;
      wsq      <= '0;
      wq       <= '0;
      poisoned <= 1'b0;
    end else if (cmd.accum) begin
      if (!s1_smiss) begin
        if (count < CW'(MAX_COLUMN_LENGTH)) begin
          count <= count + 1'b1;
          if (s1_s < rmin) rmin <= s1_s;
          if (s1_s > rmax) rmax <= s1_s;
          psum <= psum + SW'(s1_s);
          if (!s1_wmiss) begin
            wsum_s <= wsum_s + WSW'(s1_ws);
            wtot   <= wtot + SW'(s1_w);
            wsq    <= wsq + QSW'(s1_w * s1_mm);
            wq     <= wq + WQW'(s1_ww);
          end
        end
      end else if (!s1_wmiss) begin
        poisoned <= 1'b1;
      end
    end
  end

  // mode decode
  logic corrected;
  always_comb begin
    stat.last      = s1_last;
    stat.need_var  = 1'b0;
    stat.need_mean = 1'b0;
    stat.need_sqrt = 1'b0;
    case (mode) inside
      MODE_MEAN, MODE_AVG: stat.need_mean = 1'b1;
      MODE_STD, MODE_STD1: begin
        stat.need_var  = 1'b1;
        stat.need_sqrt = 1'b1;
      end
      MODE_VAR, MODE_VAR1: stat.need_var = 1'b1;
      default: ;
    endcase
  end
  assign corrected = (mode == MODE_STD1) || (mode == MODE_VAR1);

  // digit-serial multiplier: one 16-bit digit of b per cycle, top digit first
  logic [WSW-1:0]      ws_mag;
  logic [OW-1:0]       a_op;
  logic [NDIG*16-1:0]  b_op;
  logic [OW+15:0]      pp;
  logic [PW-1:0]       acc;
  logic [DGW-1:0]      dig;
  logic [1:0]          psel;
  logic [PW-1:0]       qw, ss;
  logic [DENW-1:0]     ww;

  assign ws_mag = wsum_s[WSW-1] ? (~wsum_s + 1'b1) : wsum_s;

  always_comb begin
    case (psel)
      2'd0: begin
        a_op = OW'(wsq);
        b_op = (NDIG*16)'(wtot);
      end
      2'd1: begin
        a_op = OW'(ws_mag);
        b_op = (NDIG*16)'(ws_mag);
      end
      default: begin
        a_op = OW'(wtot);
        b_op = (NDIG*16)'(wtot);
      end
    endcase
  end

  assign pp = a_op * b_op[dig*16 +: 16];

  always_ff @(posedge clk) begin
    if (cmd.mul_clr || cmd.mul_store) begin
      acc <= '0;
      dig <= DGW'(NDIG - 1);
    end else if (cmd.mul_step) begin
      acc <= (acc << 16) + PW'(pp);
      dig <= dig - 1'b1;
    end
    if (cmd.mul_clr) psel <= 2'd0;
    else if (cmd.mul_store) psel <= psel + 2'd1;
    if (cmd.mul_store) begin
      case (psel)
        2'd0:    qw <= acc;
        2'd1:    ss <= acc;
        default: ww <= DENW'(acc);
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DVW-1:0]  dvd;
  logic [DENW-1:0] rem, den;
  logic [DENW:0]   trial, diff;
  logic            ge;
  logic [PW-1:0]   num;

  assign num   = (qw >= ss) ? (qw - ss) : '0;
  assign trial = {rem, dvd[DVW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      if (stat.need_var) begin
        dvd <= {num, 16'b0};
        den <= corrected ? (ww - DENW'(wq)) : ww;
      end else begin
        dvd <= DVW'({ws_mag, 16'b0});
        den <= DENW'(wtot);
      end
    end else if (cmd.div_step) begin
      rem <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
      dvd <= {dvd[DVW-2:0], ge};
    end
  end

  logic [46:0] qsat;
  assign qsat = (|dvd[DVW-1:47]) ? '1 : dvd[46:0];

  // square root, two radicand bits per cycle
  logic [63:0] sq_v, sq_r, sq_bit, sq_t, sq_res;
  assign sq_t   = sq_r + sq_bit;
  assign sq_res = (sq_v > sq_r) ? sq_r + 64'd1 : sq_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sq_v   <= {1'b0, qsat, 16'b0};
      sq_r   <= '0;
      sq_bit <= 64'd1 << 62;
    end else if (cmd.sqrt_step) begin
      if (sq_v >= sq_t) begin
        sq_v <= sq_v - sq_t;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // result selection
  logic               rnd_up, ok, var_ok;
  logic [63:0]        mean_mag;
  logic signed [63:0] v64;
  logic [VALUE_W-1:0] res, marker;

  assign rnd_up   = ({rem, 1'b0} >= {1'b0, den});
  assign mean_mag = 64'(dvd[47:0]) + 64'(rnd_up);
  assign var_ok   = corrected ? (ww > DENW'(wq)) : (wtot != '0);
  assign marker   = {{16{missing_value[15]}}, missing_value, 16'b0};

  always_comb begin
    ok  = 1'b0;
    v64 = '0;
    case (mode) inside
      MODE_MIN: begin
        ok  = (count != '0);
        v64 = {{32{rmin[15]}}, rmin, 16'b0};
      end
      MODE_MAX: begin
        ok  = (count != '0);
        v64 = {{32{rmax[15]}}, rmax, 16'b0};
      end
      MODE_SUM: begin
        ok  = (count != '0);
        v64 = {{(48 - SW){psum[SW-1]}}, psum, 16'b0};
      end
      MODE_MEAN, MODE_AVG: begin
        ok  = (wtot != '0) && !(mode == MODE_AVG && poisoned);
        v64 = wsum_s[WSW-1] ? -$signed(mean_mag) : $signed(mean_mag);
      end
      MODE_STD, MODE_STD1: begin
        ok  = var_ok;
        v64 = $signed(sq_res);
      end
      MODE_VAR, MODE_VAR1: begin
        ok  = var_ok;
        v64 = $signed({17'b0, qsat});
      end
      default: ;
    endcase
  end

  assign res = sat48(v64);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      value      <= ok ? res : marker;
      is_missing <= !ok || (res == marker);
    end
  end

endmodule

// ----- hw/rtl/column_statistics_reducer.sv -----
// ----------------------------------------------------------------------------
// column_statistics_reducer
// Reduces one grid column of weighted samples to a single chosen statistic.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                        | content
//  ---------+-----------+--------------------------------+-------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tlast | sample, weight, weight flag
//  m_       | out       | m_tvalid m_tready m_tdata m_tuser | statistic, missing flag
//  cfg_     | in        | cfg_we cfg_addr cfg_data       | mode, missing code, skip flag
//
// Each sample beat is captured with the 16x16 products, then accumulated, and
// only then is the next beat taken. The column's last beat adds a result
// phase: min/max/sum go straight out; mean/avg load and run the bit-serial
// divider over its DVW-bit dividend (DVW = 2*(48+CW)+16, 138 at the default
// length); var first forms three products on the 16-bit digit multiplier and
// std adds the root. Reset is synchronous and clears column state and config.
// A stalled result holds in the output register while the next column's beats are taken.
module column_statistics_reducer import crs_pkg::*; #(
  parameter int MAX_COLUMN_LENGTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] sample, [31:16] weight, [32] weight_missing
  input  logic        s_tlast,   // last_in_column
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [47:0] value
  output logic        m_tuser,   // [0] is_missing
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int CW   = $clog2(MAX_COLUMN_LENGTH + 1);
  localparam int OW   = 48 + CW;
  localparam int NDIG = (OW + 15) / 16;
  localparam int DVW  = 2 * OW + 16;

  crs_cmd_t  cmd;
  crs_stat_t stat;

  // sequencer: owns the handshakes and steps the datapath
  crs_ctrl #(
    .NDIG (NDIG),
    .DVW  (DVW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // unpack the input beat straight into the datapath
  crs_datapath #(
    .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .sample         ($signed(s_tdata[15:0])),
    .weight         (s_tdata[31:16]),
    .weight_missing (s_tdata[32]),
    .last_in_column (s_tlast),
    .cmd            (cmd),
    .stat           (stat),
    .value          (m_tdata),
    .is_missing     (m_tuser)
  );

endmodule
